/* rtl/cls_pkg.sv */
// Shared types and constants of the channel log-softmax unit.
// Holds the sequencer state type and the elaboration-time builders of the
// log(1+exp(-d)) correction table. No dependencies.
package cls_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_LOOK,
      ST_CORR,
      ST_READ,
      ST_SUB,
      ST_SEND
   } state_type;

   localparam int CORR_WIDTH = 8;
   localparam logic [63:0] EXP_STEP_Q30 = 64'd1040706261;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

   typedef logic [CORR_WIDTH-1:0] corr_type;

   // restoring divide, evaluated at elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^(-k/32) to e^(-(k+1)/32), Q30
   function automatic logic [63:0] corr_next(input logic [63:0] e);
      return (e * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
   endfunction

   // round(256 * ln(1 + e)) through the atanh series, Q30 inputs
   function automatic corr_type corr_value(input logic [63:0] e);
      logic [63:0] den;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] c;
      den = (64'd1 << 31) + e;
      t   = udiv64((e << 30) + (den >> 1), den);
      t2  = (t * t) >> 30;
      p   = t;
      s   = '0;
      for (int n = 0; n < 16; n++) begin
         s = s + udiv64(p, 64'(2 * n + 1));
         p = (p * t2) >> 30;
      end
      c = ((s << 1) + (64'd1 << 21)) >> 22;
      return c[CORR_WIDTH-1:0];
   endfunction

endpackage

/* rtl/cls_corr_rom.sv */
// Correction table ROM for the log-add: 256 * ln(1 + exp(-k/32)) per entry.
// Table is built at elaboration from cls_pkg; lookup data is registered.
// Depends on cls_pkg.
module cls_corr_rom import cls_pkg::*; #(
   parameter int CORRECTION_ENTRIES = 256,
   parameter int INDEX_WIDTH = 8
) (
   input  logic                   clock,
   input  logic [INDEX_WIDTH-1:0] index,
   input  logic                   in_range,
   output corr_type               corr
);

   typedef corr_type tab_type [CORRECTION_ENTRIES];

   function automatic tab_type build_tab();
      tab_type     tab;
      logic [63:0] e;
      e = ONE_Q30;
      for (int k = 0; k < CORRECTION_ENTRIES; k++) begin
         tab[k] = corr_value(e);
         e      = corr_next(e);
      end
      return tab;
   endfunction

   localparam tab_type TAB = build_tab();

   corr_type corr_ff;
   corr_type corr_in;

   always_comb begin
      corr_in = '0;
      if (in_range) begin
         corr_in = TAB[index];
      end
   end

   always_ff @(posedge clock) begin
      corr_ff <= corr_in;
   end

   assign corr = corr_ff;

endmodule

/* rtl/channel_log_softmax_unit.sv */
// Per-pixel log-softmax over channels, signed Q8.8. A request carries one channel
// score; the request with last_channel set closes the pixel and the unit then
// returns one log_prob per stored channel in arrival order, the final one marked.
// A channel is stored when accepted; each later channel of the pixel runs the
// log-add through ST_DIFF, ST_LOOK and ST_CORR on the shared subtractor and the
// correction ROM. Each result goes through memory read, subtract and saturate,
// then hand-off, held while the result side stalls. Requests are stalled while a
// log-add or result sweep runs. Channels beyond MAX_CHANNELS per pixel are dropped.
// Depends on cls_pkg and cls_corr_rom.
module channel_log_softmax_unit import cls_pkg::*; #(
   parameter int MAX_CHANNELS = 64,
   parameter int VALUE_WIDTH = 16,
   parameter int CORRECTION_ENTRIES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_channel_value,
   input  logic                          req_last_channel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_log_prob,
   output logic                          rsp_last_result
);

   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int TAB_AW = $clog2(CORRECTION_ENTRIES);
   localparam int VW = VALUE_WIDTH;
   localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

   function automatic logic signed [VW-1:0] sat_val(input logic signed [VW:0] x);
      logic signed [VW-1:0] r;
      r = x[VW-1:0];
      if (x[VW] != x[VW-1]) begin
         r = x[VW] ? VAL_MIN : VAL_MAX;
      end
      return r;
   endfunction

   state_type state_ff, state_in;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic signed [VW-1:0] logsum_ff, logsum_in;
   logic [AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 last_ff, last_in;
   logic signed [VW-1:0] new_ff, new_in;
   logic signed [VW-1:0] max_ff, max_in;
   logic [VW:0]          abs_ff, abs_in;
   logic signed [VW-1:0] rsp_log_prob_ff, rsp_log_prob_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic signed [VW-1:0] rdata_ff;

   logic signed [VW-1:0] value_store [MAX_CHANNELS];

   logic                 accept;
   logic                 has_room;
   logic                 store_we;
   logic                 rd_en;
   logic                 is_last_rd;
   logic signed [VW-1:0] sub_a;
   logic signed [VW-1:0] sub_b;
   logic signed [VW:0]   sub_res;
   logic [VW:0]          shifted;
   logic [32:0]          shifted_ext;
   logic                 rom_in_range;
   logic [TAB_AW-1:0]    rom_index;
   corr_type             corr;
   logic signed [VW:0]   corr_sum;

   assign has_room   = count_ff < CNT_W'(MAX_CHANNELS);
   assign accept     = req_valid && !req_stall;
   assign is_last_rd = (CNT_W'(rd_ptr_ff) + CNT_W'(1)) == count_ff;

   // shared subtractor
   assign sub_res = {sub_a[VW-1], sub_a} - {sub_b[VW-1], sub_b};

   assign shifted      = abs_ff >> 3;
   assign shifted_ext  = 33'(shifted);
   assign rom_in_range = shifted_ext < 33'(CORRECTION_ENTRIES);
   assign rom_index    = shifted_ext[TAB_AW-1:0];

   cls_corr_rom #(
      .CORRECTION_ENTRIES(CORRECTION_ENTRIES),
      .INDEX_WIDTH(TAB_AW)
   ) u_corr_rom (
      .clock(clock),
      .index(rom_index),
      .in_range(rom_in_range),
      .corr(corr)
   );

   assign corr_sum = {max_ff[VW-1], max_ff} + {(VW+1-CORR_WIDTH)'(0), corr};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (has_room && count_ff != '0) begin
                  state_in = ST_DIFF;
               end else if (req_last_channel) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_DIFF: state_in = ST_LOOK;
         ST_LOOK: state_in = ST_CORR;
         ST_CORR: state_in = last_ff ? ST_READ : ST_IDLE;
         ST_READ: state_in = ST_SUB;
         ST_SUB:  state_in = ST_SEND;
         ST_SEND: begin
            if (!rsp_stall) begin
               state_in = rsp_last_ff ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      store_we  = 1'b0;
      rd_en     = 1'b0;
      sub_a     = logsum_ff;
      sub_b     = new_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            store_we  = req_valid && has_room;
         end
         ST_READ: rd_en = 1'b1;
         ST_SUB: begin
            sub_a = rdata_ff;
            sub_b = logsum_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in        = count_ff;
      logsum_in       = logsum_ff;
      rd_ptr_in       = rd_ptr_ff;
      rsp_valid_in    = rsp_valid_ff;
      last_in         = last_ff;
      new_in          = new_ff;
      max_in          = max_ff;
      abs_in          = abs_ff;
      rsp_log_prob_in = rsp_log_prob_ff;
      rsp_last_in     = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_last_channel;
               new_in  = req_channel_value;
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
                  if (count_ff == '0) begin
                     logsum_in = req_channel_value;
                  end
               end
            end
         end
         ST_DIFF: begin
            max_in = sub_res[VW] ? new_ff : logsum_ff;
            abs_in = sub_res[VW] ? (VW+1)'(-sub_res) : (VW+1)'(sub_res);
         end
         ST_CORR: logsum_in = sat_val(corr_sum);
         ST_SUB: begin
            rsp_log_prob_in = sat_val(sub_res);
            rsp_last_in     = is_last_rd;
            rsp_valid_in    = 1'b1;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in  = '0;
                  logsum_in = VAL_MIN;
                  rd_ptr_in = '0;
               end else begin
                  rd_ptr_in = rd_ptr_ff + AW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         logsum_ff    <= VAL_MIN;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         logsum_ff    <= logsum_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff         <= last_in;
      new_ff          <= new_in;
      max_ff          <= max_in;
      abs_ff          <= abs_in;
      rsp_log_prob_ff <= rsp_log_prob_in;
      rsp_last_ff     <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         value_store[count_ff[AW-1:0]] <= req_channel_value;
      end
      if (rd_en) begin
         rdata_ff <= value_store[rd_ptr_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_log_prob    = rsp_log_prob_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule
